[hdl/les_pkg.sv]
// Shared types and codes for the LOOK elevator scheduler.
`default_nettype none
package les_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_ACT    = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/les_ctrl.sv]
// Sequencer for the LOOK elevator scheduler: load, table scan, drain and commit.
`default_nettype none
module les_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        in_command,
  input  wire les_pkg::dp_stat_t stat,
  output les_pkg::ctl_t          ctl,
  output logic                   busy,
  output les_pkg::state_t        state
);

  les_pkg::state_t state_r;
  les_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= les_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      les_pkg::S_IDLE: begin
        if (start) begin
          if (les_pkg::cmd_t'(in_command) == les_pkg::CMD_LOCATE) begin
            state_nxt = les_pkg::S_COMMIT;
          end else begin
            state_nxt = les_pkg::S_SCAN;
          end
        end
      end
      les_pkg::S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = les_pkg::S_DRAIN;
        end
      end
      les_pkg::S_DRAIN: begin
        state_nxt = les_pkg::S_COMMIT;
      end
      les_pkg::S_COMMIT: begin
        state_nxt = les_pkg::S_IDLE;
      end
      default: begin
        state_nxt = les_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      les_pkg::S_IDLE:   ctl.load = start;
      les_pkg::S_SCAN:   ctl.scan = 1'b1;
      les_pkg::S_DRAIN:  ctl = '0;
      les_pkg::S_COMMIT: ctl.commit = 1'b1;
      default:           ctl = '0;
    endcase
  end

  assign busy  = (state_r != les_pkg::S_IDLE);
  assign state = state_r;

endmodule
`default_nettype wire

[hdl/les_dpath.sv]
// Datapath: request table, scan accumulators, position, direction and result registers.
`default_nettype none
module les_dpath #(
  parameter int PENDING_DEPTH = 64,
  parameter int FLOOR_BITS    = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire les_pkg::ctl_t         ctl,
  input  wire logic [1:0]            in_command,
  input  wire logic [FLOOR_BITS-1:0] in_floor,
  output les_pkg::dp_stat_t          stat,
  output logic                       out_valid,
  output logic [FLOOR_BITS-1:0]      out_current_floor,
  output logic                       out_going_up,
  output logic [1:0]                 out_status
);

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  logic [FLOOR_BITS-1:0] mem [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] valid_r, valid_nxt;

  les_pkg::cmd_t         cmd_r;
  logic [FLOOR_BITS-1:0] floor_r;
  logic [FLOOR_BITS-1:0] cur_r, cur_nxt;
  logic                  dir_up_r, dir_up_nxt;

  logic [AW-1:0]         addr_r;
  logic [FLOOR_BITS-1:0] rd_floor_r;
  logic                  rd_valid_r;
  logic [AW-1:0]         rd_idx_r;
  logic                  rd_live_r;

  logic                  match_found_r, free_found_r, up_found_r, dn_found_r;
  logic [AW-1:0]         match_idx_r, free_idx_r, up_idx_r, dn_idx_r;
  logic [FLOOR_BITS-1:0] up_floor_r, dn_floor_r;

  logic                  we;
  logic [AW-1:0]         waddr;
  les_pkg::status_t      status_nxt;

  logic                  out_valid_r;
  logic [FLOOR_BITS-1:0] out_floor_r;
  logic                  out_up_r;
  les_pkg::status_t      out_status_r;

  assign stat.scan_last = (addr_r == AW'(PENDING_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= floor_r;
    end
    rd_floor_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= les_pkg::cmd_t'(in_command);
      floor_r <= in_floor;
    end
    rd_valid_r <= valid_r[addr_r];
    rd_idx_r   <= addr_r;
    if (rd_live_r) begin
      if (rd_valid_r && (rd_floor_r == floor_r) && !match_found_r) begin
        match_idx_r <= rd_idx_r;
      end
      if (!rd_valid_r && !free_found_r) begin
        free_idx_r <= rd_idx_r;
      end
      if (rd_valid_r && (rd_floor_r > cur_r) && (!up_found_r || (rd_floor_r < up_floor_r))) begin
        up_idx_r   <= rd_idx_r;
        up_floor_r <= rd_floor_r;
      end
      if (rd_valid_r && (rd_floor_r < cur_r) && (!dn_found_r || (rd_floor_r > dn_floor_r))) begin
        dn_idx_r   <= rd_idx_r;
        dn_floor_r <= rd_floor_r;
      end
    end
    out_floor_r  <= cur_nxt;
    out_up_r     <= dir_up_nxt;
    out_status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      cur_r         <= '0;
      dir_up_r      <= 1'b1;
      addr_r        <= '0;
      rd_live_r     <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      up_found_r    <= 1'b0;
      dn_found_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      cur_r       <= cur_nxt;
      dir_up_r    <= dir_up_nxt;
      rd_live_r   <= ctl.scan;
      out_valid_r <= ctl.commit;
      if (ctl.load) begin
        addr_r        <= '0;
        match_found_r <= 1'b0;
        free_found_r  <= 1'b0;
        up_found_r    <= 1'b0;
        dn_found_r    <= 1'b0;
      end else begin
        if (ctl.scan) begin
          addr_r <= addr_r + AW'(1);
        end
        if (rd_live_r) begin
          if (rd_valid_r && (rd_floor_r == floor_r)) begin
            match_found_r <= 1'b1;
          end
          if (!rd_valid_r) begin
            free_found_r <= 1'b1;
          end
          if (rd_valid_r && (rd_floor_r > cur_r)) begin
            up_found_r <= 1'b1;
          end
          if (rd_valid_r && (rd_floor_r < cur_r)) begin
            dn_found_r <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    cur_nxt    = cur_r;
    dir_up_nxt = dir_up_r;
    status_nxt = les_pkg::ST_DONE;
    we         = 1'b0;
    waddr      = free_idx_r;
    if (ctl.commit) begin
      unique case (cmd_r)
        les_pkg::CMD_ADD: begin
          if ((floor_r == cur_r) || match_found_r) begin
            status_nxt = les_pkg::ST_IGNORED;
          end else if (!free_found_r) begin
            status_nxt = les_pkg::ST_FULL;
          end else begin
            we                    = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
          end
        end
        les_pkg::CMD_CANCEL: begin
          if (match_found_r) begin
            valid_nxt[match_idx_r] = 1'b0;
          end else begin
            status_nxt = les_pkg::ST_IGNORED;
          end
        end
        les_pkg::CMD_ACT: begin
          if (dir_up_r && up_found_r) begin
            cur_nxt             = up_floor_r;
            valid_nxt[up_idx_r] = 1'b0;
          end else if (!dir_up_r && dn_found_r) begin
            cur_nxt             = dn_floor_r;
            valid_nxt[dn_idx_r] = 1'b0;
          end else if (dir_up_r && dn_found_r) begin
            cur_nxt             = dn_floor_r;
            valid_nxt[dn_idx_r] = 1'b0;
            dir_up_nxt          = 1'b0;
          end else if (!dir_up_r && up_found_r) begin
            cur_nxt             = up_floor_r;
            valid_nxt[up_idx_r] = 1'b0;
            dir_up_nxt          = 1'b1;
          end else begin
            status_nxt = les_pkg::ST_EMPTY;
          end
        end
        les_pkg::CMD_LOCATE: begin
          status_nxt = les_pkg::ST_DONE;
        end
        default: begin
          status_nxt = les_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_floor = out_floor_r;
  assign out_going_up      = out_up_r;
  assign out_status        = out_status_r;

endmodule
`default_nettype wire

[hdl/look_elevator_scheduler.sv]
// Top level of the LOOK elevator scheduler: sequencer, datapath and assertions.
//
// A command word is taken when start is high and busy is low. Add, cancel and act
// walk the whole request table through the single read port of its memory, one
// entry per cycle, then pass through a drain state and a commit state; busy stays
// high throughout, and no new command is taken until it drops. Locate needs no
// scan and goes straight from idle to commit. The result word appears
// on out_current_floor, out_going_up and out_status for exactly one cycle, flagged by
// out_valid, in the cycle in which busy drops; the receiver cannot stall it, so it must
// capture every word in that cycle. A new command may be started in that same cycle.
`default_nettype none
module look_elevator_scheduler #(
  parameter int PENDING_DEPTH = 64,
  parameter int FLOOR_BITS    = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_command,
  input  wire logic [FLOOR_BITS-1:0] in_floor,
  output logic                       out_valid,
  output logic [FLOOR_BITS-1:0]      out_current_floor,
  output logic                       out_going_up,
  output logic [1:0]                 out_status
);

  les_pkg::ctl_t     ctl;
  les_pkg::dp_stat_t stat;
  les_pkg::state_t   state;

  les_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .ctl        (ctl),
    .busy       (busy),
    .state      (state)
  );

  les_dpath #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .FLOOR_BITS    (FLOOR_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .in_command        (in_command),
    .in_floor          (in_floor),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_current_floor (out_current_floor),
    .out_going_up      (out_going_up),
    .out_status        (out_status)
  );

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_commit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state == les_pkg::S_COMMIT) |=> (out_valid && !busy))
    else $error("commit did not produce a result word");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_drain_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state == les_pkg::S_DRAIN) |=> (state == les_pkg::S_COMMIT))
    else $error("scan drain did not lead to commit");
`endif

endmodule
`default_nettype wire
